### hw/rtl/sls_pkg.sv
package sls_pkg;

    // Operation codes carried by an input transaction
    typedef enum logic [1:0] {
        OP_INSERT = 2'd0,
        OP_REMOVE = 2'd1,
        OP_SEARCH = 2'd2,
        OP_LIST   = 2'd3
    } op_t;

    // Result status codes
    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_EMPTY   = 2'd1,
        ST_MISSING = 2'd2,
        ST_FULL    = 2'd3
    } status_t;

    localparam int VALUE_W = 32;

    // Walk counter update
    typedef enum logic [2:0] {
        CNT_HOLD = 3'd0,
        CNT_CLR  = 3'd1,
        CNT_FILL = 3'd2,
        CNT_INC  = 3'd3,
        CNT_DEC  = 3'd4
    } cnt_op_t;

    // Fill count update
    typedef enum logic [1:0] {
        FILL_HOLD = 2'd0,
        FILL_INC  = 2'd1,
        FILL_DEC  = 2'd2
    } fill_op_t;

    // Memory address source: the walk counter or the slot below it
    typedef enum logic {
        ADDR_CNT  = 1'b0,
        ADDR_PREV = 1'b1
    } addr_sel_t;

    // Memory write data source
    typedef enum logic {
        WD_ITEM  = 1'b0,
        WD_RDATA = 1'b1
    } wdata_sel_t;

    // Result value source
    typedef enum logic [1:0] {
        VAL_ZERO  = 2'd0,
        VAL_ITEM  = 2'd1,
        VAL_RDATA = 2'd2
    } val_sel_t;

    // Commands from controller to datapath
    typedef struct packed {
        logic       load;
        cnt_op_t    cnt_op;
        fill_op_t   fill_op;
        logic       rd_en;
        addr_sel_t  rd_addr;
        logic       wr_en;
        addr_sel_t  wr_addr;
        wdata_sel_t wr_data;
        logic       found_set;
        logic       emit;
        status_t    emit_status;
        val_sel_t   emit_val;
        logic       emit_last;
    } cmd_t;

    // Status from datapath to controller
    typedef struct packed {
        logic fill_zero;
        logic full;
        logic cnt_zero;
        logic cnt_at_fill;
        logic cnt_at_last;
        logic le;
        logic eq;
        logic found;
    } stat_t;

endpackage

### hw/rtl/sls_datapath.sv
module sls_datapath #(
    parameter int CAPACITY = 16
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  sls_pkg::cmd_t                      cmd,
    output sls_pkg::stat_t                     stat,
    input  logic signed [sls_pkg::VALUE_W-1:0] item_value,
    output logic                               result_valid,
    output logic [1:0]                         status,
    output logic signed [sls_pkg::VALUE_W-1:0] out_value,
    output logic                               last
);

    localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CW = $clog2(CAPACITY + 1);

    logic signed [sls_pkg::VALUE_W-1:0] mem [CAPACITY];
    logic signed [sls_pkg::VALUE_W-1:0] rdata_reg;
    logic signed [sls_pkg::VALUE_W-1:0] item_reg;

    logic [CW-1:0] cnt_reg, cnt_next;
    logic [CW-1:0] fill_reg, fill_next;
    logic [CW-1:0] cnt_prev;
    logic          found_reg, found_next;

    logic [AW-1:0]                      rd_addr;
    logic [AW-1:0]                      wr_addr;
    logic signed [sls_pkg::VALUE_W-1:0] wr_data;
    logic signed [sls_pkg::VALUE_W-1:0] emit_value;

    logic                               result_valid_reg;
    logic [1:0]                         status_reg;
    logic signed [sls_pkg::VALUE_W-1:0] out_value_reg;
    logic                               last_reg;

    assign cnt_prev = cnt_reg - CW'(1);

    // Select memory addresses and write data
    assign rd_addr = (cmd.rd_addr == sls_pkg::ADDR_PREV) ? cnt_prev[AW-1:0] : cnt_reg[AW-1:0];
    assign wr_addr = (cmd.wr_addr == sls_pkg::ADDR_PREV) ? cnt_prev[AW-1:0] : cnt_reg[AW-1:0];
    assign wr_data = (cmd.wr_data == sls_pkg::WD_RDATA) ? rdata_reg : item_reg;

    // Entry storage: one write and one registered read per cycle
    always_ff @(posedge clk)
    begin
        if (cmd.wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (cmd.rd_en)
        begin
            rdata_reg <= mem[rd_addr];
        end
    end

    // Capture the item value
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            item_reg <= item_value;
        end
    end

    // Walk counter
    always_comb
    begin
        unique case (cmd.cnt_op)
            sls_pkg::CNT_CLR:  cnt_next = '0;
            sls_pkg::CNT_FILL: cnt_next = fill_reg;
            sls_pkg::CNT_INC:  cnt_next = cnt_reg + CW'(1);
            sls_pkg::CNT_DEC:  cnt_next = cnt_prev;
            default:           cnt_next = cnt_reg;
        endcase
    end

    // Fill count
    always_comb
    begin
        unique case (cmd.fill_op)
            sls_pkg::FILL_INC: fill_next = fill_reg + CW'(1);
            sls_pkg::FILL_DEC: fill_next = fill_reg - CW'(1);
            default:           fill_next = fill_reg;
        endcase
    end

    // Match flag for remove and search
    always_comb
    begin
        found_next = found_reg;
        if (cmd.load)
        begin
            found_next = 1'b0;
        end
        else if (cmd.found_set)
        begin
            found_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg   <= '0;
            fill_reg  <= '0;
            found_reg <= 1'b0;
        end
        else
        begin
            cnt_reg   <= cnt_next;
            fill_reg  <= fill_next;
            found_reg <= found_next;
        end
    end

    // Status toward the controller
    assign stat.fill_zero   = (fill_reg == '0);
    assign stat.full        = (fill_reg == CW'(CAPACITY));
    assign stat.cnt_zero    = (cnt_reg == '0);
    assign stat.cnt_at_fill = (cnt_reg == fill_reg);
    assign stat.cnt_at_last = (cnt_reg == fill_reg - CW'(1));
    assign stat.le          = (item_reg <= rdata_reg);
    assign stat.eq          = (item_reg == rdata_reg);
    assign stat.found       = found_reg;

    // Result value select
    always_comb
    begin
        unique case (cmd.emit_val)
            sls_pkg::VAL_ITEM:  emit_value = item_reg;
            sls_pkg::VAL_RDATA: emit_value = rdata_reg;
            default:            emit_value = '0;
        endcase
    end

    // Result strobe
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_valid_reg <= 1'b0;
        end
        else
        begin
            result_valid_reg <= cmd.emit;
        end
    end

    // Result payload
    always_ff @(posedge clk)
    begin
        if (cmd.emit)
        begin
            status_reg    <= cmd.emit_status;
            out_value_reg <= emit_value;
            last_reg      <= cmd.emit_last;
        end
    end

    assign result_valid = result_valid_reg;
    assign status       = status_reg;
    assign out_value    = out_value_reg;
    assign last         = last_reg;

endmodule

### hw/rtl/sls_controller.sv
module sls_controller (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           start,
    input  logic [1:0]     op,
    output logic           busy,
    output sls_pkg::cmd_t  cmd,
    input  sls_pkg::stat_t stat
);

    typedef enum logic [4:0] {
        S_IDLE     = 5'b00001,
        S_INS_RD   = 5'b00010,
        S_INS_CMP  = 5'b00100,
        S_WALK_RD  = 5'b01000,
        S_WALK_CMP = 5'b10000
    } state_t;

    state_t         state_reg, state_next;
    sls_pkg::op_t   op_reg, op_next;
    sls_pkg::op_t   op_in;

    assign op_in = sls_pkg::op_t'(op);
    assign busy  = (state_reg != S_IDLE);

    always_comb
    begin
        state_next = state_reg;
        op_next    = op_reg;

        cmd             = '0;
        cmd.cnt_op      = sls_pkg::CNT_HOLD;
        cmd.fill_op     = sls_pkg::FILL_HOLD;
        cmd.rd_addr     = sls_pkg::ADDR_CNT;
        cmd.wr_addr     = sls_pkg::ADDR_CNT;
        cmd.wr_data     = sls_pkg::WD_ITEM;
        cmd.emit_status = sls_pkg::ST_OK;
        cmd.emit_val    = sls_pkg::VAL_ZERO;

        unique case (state_reg)
            S_IDLE:
            begin
                // Accept a transaction, or answer at once on full or empty
                if (start)
                begin
                    op_next = op_in;
                    if (op_in == sls_pkg::OP_INSERT)
                    begin
                        if (stat.full)
                        begin
                            cmd.emit        = 1'b1;
                            cmd.emit_status = sls_pkg::ST_FULL;
                            cmd.emit_last   = 1'b1;
                        end
                        else
                        begin
                            cmd.load   = 1'b1;
                            cmd.cnt_op = sls_pkg::CNT_FILL;
                            state_next = S_INS_RD;
                        end
                    end
                    else if (stat.fill_zero)
                    begin
                        cmd.emit        = 1'b1;
                        cmd.emit_status = sls_pkg::ST_EMPTY;
                        cmd.emit_last   = 1'b1;
                    end
                    else
                    begin
                        cmd.load   = 1'b1;
                        cmd.cnt_op = sls_pkg::CNT_CLR;
                        state_next = S_WALK_RD;
                    end
                end
            end

            S_INS_RD:
            begin
                // Bottom reached: place the value in slot zero
                if (stat.cnt_zero)
                begin
                    cmd.wr_en       = 1'b1;
                    cmd.wr_addr     = sls_pkg::ADDR_CNT;
                    cmd.wr_data     = sls_pkg::WD_ITEM;
                    cmd.fill_op     = sls_pkg::FILL_INC;
                    cmd.emit        = 1'b1;
                    cmd.emit_status = sls_pkg::ST_OK;
                    cmd.emit_val    = sls_pkg::VAL_ITEM;
                    cmd.emit_last   = 1'b1;
                    state_next      = S_IDLE;
                end
                else
                begin
                    cmd.rd_en   = 1'b1;
                    cmd.rd_addr = sls_pkg::ADDR_PREV;
                    state_next  = S_INS_CMP;
                end
            end

            S_INS_CMP:
            begin
                if (stat.le)
                begin
                    // Shift the entry up one slot and keep walking down
                    cmd.wr_en   = 1'b1;
                    cmd.wr_addr = sls_pkg::ADDR_CNT;
                    cmd.wr_data = sls_pkg::WD_RDATA;
                    cmd.cnt_op  = sls_pkg::CNT_DEC;
                    state_next  = S_INS_RD;
                end
                else
                begin
                    // Smaller entry found: drop the value in above it
                    cmd.wr_en       = 1'b1;
                    cmd.wr_addr     = sls_pkg::ADDR_CNT;
                    cmd.wr_data     = sls_pkg::WD_ITEM;
                    cmd.fill_op     = sls_pkg::FILL_INC;
                    cmd.emit        = 1'b1;
                    cmd.emit_status = sls_pkg::ST_OK;
                    cmd.emit_val    = sls_pkg::VAL_ITEM;
                    cmd.emit_last   = 1'b1;
                    state_next      = S_IDLE;
                end
            end

            S_WALK_RD:
            begin
                if (stat.cnt_at_fill)
                begin
                    // End of the walk: report remove and search outcome
                    state_next = S_IDLE;
                    if (op_reg == sls_pkg::OP_REMOVE || op_reg == sls_pkg::OP_SEARCH)
                    begin
                        cmd.emit      = 1'b1;
                        cmd.emit_last = 1'b1;
                        if (stat.found)
                        begin
                            cmd.emit_status = sls_pkg::ST_OK;
                            if (op_reg == sls_pkg::OP_REMOVE)
                            begin
                                cmd.emit_val = sls_pkg::VAL_ITEM;
                                cmd.fill_op  = sls_pkg::FILL_DEC;
                            end
                        end
                        else
                        begin
                            cmd.emit_status = sls_pkg::ST_MISSING;
                        end
                    end
                end
                else
                begin
                    cmd.rd_en   = 1'b1;
                    cmd.rd_addr = sls_pkg::ADDR_CNT;
                    state_next  = S_WALK_CMP;
                end
            end

            S_WALK_CMP:
            begin
                cmd.cnt_op = sls_pkg::CNT_INC;
                state_next = S_WALK_RD;
                unique case (op_reg)
                    sls_pkg::OP_REMOVE:
                    begin
                        // After the match, move each entry down one slot
                        if (stat.found)
                        begin
                            cmd.wr_en   = 1'b1;
                            cmd.wr_addr = sls_pkg::ADDR_PREV;
                            cmd.wr_data = sls_pkg::WD_RDATA;
                        end
                        else if (stat.eq)
                        begin
                            cmd.found_set = 1'b1;
                        end
                    end
                    sls_pkg::OP_SEARCH:
                    begin
                        if (stat.eq)
                        begin
                            cmd.found_set = 1'b1;
                        end
                    end
                    sls_pkg::OP_LIST:
                    begin
                        cmd.emit        = 1'b1;
                        cmd.emit_status = sls_pkg::ST_OK;
                        cmd.emit_val    = sls_pkg::VAL_RDATA;
                        cmd.emit_last   = stat.cnt_at_last;
                    end
                    sls_pkg::OP_INSERT:
                    begin
                        // insert never walks upward
                    end
                endcase
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            op_reg    <= sls_pkg::OP_INSERT;
        end
        else
        begin
            state_reg <= state_next;
            op_reg    <= op_next;
        end
    end

endmodule

### hw/rtl/sorted_list_store_unit.sv
// Sorted store of up to CAPACITY signed 32-bit values in ascending order. A
// transaction is taken when start is high and busy is low; busy then stays high
// while the entries are walked through the entry memory, which has one write
// port and one registered read port. Insert into a full store and remove, search
// or list on an empty store leave busy low. Every result is driven for exactly
// one cycle with result_valid high, starting the cycle after the deciding edge;
// there is no backpressure, so the receiver must capture each result as it
// appears. List gives one result per entry with last set on the final one; every
// other transaction gives a single result.
module sorted_list_store_unit #(
    parameter int CAPACITY = 16
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               start,
    output logic                               busy,
    input  logic [1:0]                         op,
    input  logic signed [sls_pkg::VALUE_W-1:0] item_value,
    output logic                               result_valid,
    output logic [1:0]                         status,
    output logic signed [sls_pkg::VALUE_W-1:0] out_value,
    output logic                               last
);

    sls_pkg::cmd_t  cmd;
    sls_pkg::stat_t stat;

    sls_controller u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .op    (op),
        .busy  (busy),
        .cmd   (cmd),
        .stat  (stat)
    );

    sls_datapath #(
        .CAPACITY (CAPACITY)
    ) u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .stat         (stat),
        .item_value   (item_value),
        .result_valid (result_valid),
        .status       (status),
        .out_value    (out_value),
        .last         (last)
    );

endmodule

### test/tb_top.sv
module tb_top;

    import sls_pkg::*;

    localparam int CAPACITY     = 16;
    localparam int RANDOM_ITEMS = 350;
    localparam int CYCLE_LIMIT  = 200000;
    localparam int DRAIN_CYCLES = 2 * CAPACITY + 8;
    localparam int REPORT_MAX   = 10;

    typedef struct {
        op_t                         kind;
        logic signed [VALUE_W-1:0]   value;
    } store_cmd_t;

    typedef struct {
        status_t                     status;
        logic signed [VALUE_W-1:0]   value;
        logic                        last;
    } store_result_t;

    logic                        clk = 1'b0;
    logic                        rst_n = 1'b0;
    logic                        start = 1'b0;
    logic                        busy;
    logic [1:0]                  op = 2'd0;
    logic signed [VALUE_W-1:0]   item_value = '0;
    logic                        result_valid;
    logic [1:0]                  status;
    logic signed [VALUE_W-1:0]   out_value;
    logic                        last;

    // Stimulus and prediction state
    store_cmd_t                  pending_cmds[$];
    store_result_t               predicted_results[$];
    logic signed [VALUE_W-1:0]   sorted_shadow[$];
    logic                        took_last = 1'b0;
    int                          burst_left = 0;
    int                          gap_left = 0;
    int                          accepted_count = 0;
    int                          total_cmds = 0;
    int                          checked_count = 0;
    int                          error_count = 0;
    int                          full_drops = 0;
    int                          empty_replies = 0;
    int                          missing_replies = 0;
    int                          op_counts[4] = '{0, 0, 0, 0};
    int                          cycle_count = 0;

    sorted_list_store_unit #(
        .CAPACITY(CAPACITY)
    ) u_top (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .busy        (busy),
        .op          (op),
        .item_value  (item_value),
        .result_valid(result_valid),
        .status      (status),
        .out_value   (out_value),
        .last        (last)
    );

    // Clock: 8 time unit period
    always
    begin
        #4 clk = 1'b1;
        #4 clk = 0;
    end

    task automatic queue_cmd(input op_t kind, input logic signed [VALUE_W-1:0] value);
        store_cmd_t cmd;
        cmd.kind  = kind;
        cmd.value = value;
        pending_cmds.push_back(cmd);
    endtask

    // Apply one transaction to the sorted shadow list and queue its results
    task automatic predict_store_op(input op_t kind, input logic signed [VALUE_W-1:0] value);
        store_result_t res;
        int            pos;
        res.status = ST_OK;
        res.value  = '0;
        res.last   = 1'b1;
        if (kind == OP_LIST && sorted_shadow.size() > 0)
        begin
            for (int i = 0; i < sorted_shadow.size(); i++)
            begin
                res.value = sorted_shadow[i];
                res.last  = (i == sorted_shadow.size() - 1);
                predicted_results.push_back(res);
            end
        end
        else
        begin
            case (kind)
                OP_INSERT:
                begin
                    if (sorted_shadow.size() >= CAPACITY)
                    begin
                        res.status = ST_FULL;
                        full_drops++;
                    end
                    else
                    begin
                        // place ahead of the first entry that is not smaller
                        pos = 0;
                        while (pos < sorted_shadow.size() && value > sorted_shadow[pos])
                            pos++;
                        sorted_shadow.insert(pos, value);
                        res.value = value;
                    end
                end
                default:
                begin
                    if (sorted_shadow.size() == 0)
                    begin
                        res.status = ST_EMPTY;
                        empty_replies++;
                    end
                    else
                    begin
                        pos = -1;
                        for (int i = 0; i < sorted_shadow.size(); i++)
                        begin
                            if (pos < 0 && sorted_shadow[i] == value)
                                pos = i;
                        end
                        if (pos < 0)
                        begin
                            res.status = ST_MISSING;
                            missing_replies++;
                        end
                        else if (kind == OP_REMOVE)
                        begin
                            sorted_shadow.delete(pos);
                            res.value = value;
                        end
                    end
                end
            endcase
            predicted_results.push_back(res);
        end
    endtask

    task automatic flag_error(input string msg);
        error_count++;
        if (error_count <= REPORT_MAX)
            $display("ERROR @%0t: %s", $realtime, msg);
    endtask

    // Driver: present transactions at the falling edge, in bursts with random gaps
    always @(negedge clk)
    begin
        store_cmd_t cmd;
        logic       next_start;
        if (rst_n && !(start && !took_last))
        begin
            next_start = 1'b0;
            if (gap_left > 0)
                gap_left--;
            else if (pending_cmds.size() > 0)
            begin
                cmd = pending_cmds.pop_front();
                next_start = 1'b1;
                op <= cmd.kind;
                item_value <= cmd.value;
                if (burst_left == 0)
                    burst_left = $urandom_range(1, 12);
                burst_left--;
                if (burst_left == 0)
                    gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            end
            start <= next_start;
        end
    end

    // Monitor: check results and predict accepted transactions at the rising edge
    always @(posedge clk)
    begin
        store_result_t want;
        took_last <= start && !busy;
        if (rst_n)
        begin
            if (result_valid)
            begin
                checked_count++;
                if (predicted_results.size() == 0)
                    flag_error($sformatf("unexpected result status=%0d value=%0d last=%0b",
                                         status, out_value, last));
                else
                begin
                    want = predicted_results.pop_front();
                    if (status !== want.status || out_value !== want.value
                        || last !== want.last)
                        flag_error($sformatf({"result mismatch: ",
                            "exp status=%0d value=%0d last=%0b, ",
                            "got status=%0d value=%0d last=%0b"},
                            want.status, want.value, want.last, status, out_value, last));
                end
            end
            if (start && !busy)
            begin
                accepted_count++;
                op_counts[op]++;
                predict_store_op(op_t'(op), item_value);
            end
        end
    end

    // Timeout guard
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("Timeout after %0d cycles", cycle_count);
            $display("Simulation FAILED");
            $finish;
        end
    end

    initial
    begin
        logic signed [VALUE_W-1:0] value_pool[8];
        int                        random_count;
        int                        phase;
        int                        phase_len;
        int                        roll;
        int                        ins_pct;
        int                        rem_pct;
        int                        srch_pct;
        int                        vsel;
        op_t                       kind;
        logic signed [VALUE_W-1:0] value;

        // Empty-store responses
        queue_cmd(OP_LIST, 0);
        queue_cmd(OP_REMOVE, 5);
        queue_cmd(OP_SEARCH, 5);
        // Extremes, first insert into empty store, and an equal value
        queue_cmd(OP_INSERT, 32'sh7FFF_FFFF);
        queue_cmd(OP_INSERT, 32'sh8000_0000);
        queue_cmd(OP_INSERT, 0);
        queue_cmd(OP_INSERT, -1);
        queue_cmd(OP_INSERT, 0);
        // Hit and miss for search and remove
        queue_cmd(OP_SEARCH, 0);
        queue_cmd(OP_SEARCH, 1234);
        queue_cmd(OP_REMOVE, 99);
        queue_cmd(OP_REMOVE, 0);
        queue_cmd(OP_LIST, 0);
        // Fill to capacity, then overflow and list the full store
        for (int i = 0; i < CAPACITY - 4; i++)
            queue_cmd(OP_INSERT, i * 3 - 10);
        queue_cmd(OP_INSERT, 42);
        queue_cmd(OP_LIST, 0);

        // Value pool: repeats give hits and duplicates
        value_pool[0] = 32'sh8000_0000;
        value_pool[1] = 32'sh7FFF_FFFF;
        for (int i = 2; i < 8; i++)
            value_pool[i] = ($urandom_range(0, 1) == 1) ? $urandom : $urandom_range(0, 20) - 10;

        // Random phases that lean toward filling, draining or a mix
        random_count = 0;
        while (random_count < RANDOM_ITEMS)
        begin
            phase = $urandom_range(0, 2);
            phase_len = $urandom_range(15, 45);
            case (phase)
                0:       begin ins_pct = 65; rem_pct = 80; srch_pct = 92; end
                1:       begin ins_pct = 20; rem_pct = 70; srch_pct = 90; end
                default: begin ins_pct = 35; rem_pct = 60; srch_pct = 88; end
            endcase
            for (int n = 0; n < phase_len && random_count < RANDOM_ITEMS; n++)
            begin
                roll = $urandom_range(0, 99);
                kind = (roll < ins_pct) ? OP_INSERT :
                       (roll < rem_pct) ? OP_REMOVE :
                       (roll < srch_pct) ? OP_SEARCH : OP_LIST;
                vsel = $urandom_range(0, 9);
                if (vsel < 6)
                    value = value_pool[$urandom_range(0, 7)];
                else if (vsel < 8)
                    value = $urandom_range(0, 8) - 4;
                else
                    value = $urandom;
                queue_cmd(kind, value);
                random_count++;
            end
        end
        total_cmds = pending_cmds.size();

        // Hold reset, then release it at a falling edge
        rst_n = 1'b0;
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Wait until every transaction is taken and every result has arrived
        do
            @(negedge clk);
        while (accepted_count < total_cmds || predicted_results.size() != 0);
        repeat (DRAIN_CYCLES) @(negedge clk);

        $display({"Ran %0d transactions (insert %0d, remove %0d, search %0d, list %0d), ",
                  "%0d results checked"},
                 accepted_count, op_counts[OP_INSERT], op_counts[OP_REMOVE],
                 op_counts[OP_SEARCH], op_counts[OP_LIST], checked_count);
        $display("Full-store drops %0d, empty-store replies %0d, not-found replies %0d, errors %0d",
                 full_drops, empty_replies, missing_replies, error_count);
        if (error_count == 0 && predicted_results.size() == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule

### sorted_list_store_unit.f
hw/rtl/sls_pkg.sv
hw/rtl/sls_datapath.sv
hw/rtl/sls_controller.sv
hw/rtl/sorted_list_store_unit.sv
test/tb_top.sv
